// ===== src/entity_id_allocator_with_signatures_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on nothing; users provide clk and arst_n in scope.
`ifndef ENTITY_ID_ALLOCATOR_WITH_SIGNATURES_MACROS_SVH
`define ENTITY_ID_ALLOCATOR_WITH_SIGNATURES_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define EIA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");
// Next-cycle implication, disabled during reset.
`define EIA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");
`else
`define EIA_ASSERT_IMP(label, ante, cons)
`define EIA_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== src/eia_pkg.sv =====
// Package for the entity ID allocator: sizes, operation and error codes, helpers.
// Depends on nothing.
package eia_pkg;

	localparam int ID_COUNT = 256;
	localparam int ID_W     = $clog2(ID_COUNT);
	localparam int TOP_W    = $clog2(ID_COUNT + 1);
	localparam int SIG_BITS = 32;
	localparam int OP_W     = 3;
	localparam int BIT_W    = 5;
	localparam int ERR_W    = 2;

	typedef logic [ID_W-1:0]     id_t;
	typedef logic [TOP_W-1:0]    top_t;
	typedef logic [SIG_BITS-1:0] sig_t;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE    = 3'd0,
		OP_DESTROY   = 3'd1,
		OP_SET       = 3'd2,
		OP_CLEAR     = 3'd3,
		OP_TEST_BIT  = 3'd4,
		OP_TEST_LIVE = 3'd5
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE     = 2'd0,
		ERR_NO_FREE  = 2'd1,
		ERR_NOT_LIVE = 2'd2
	} err_t;

	// One-hot mask for a signature bit; an index past the signature width gives no bit.
	function automatic sig_t bit_mask(input logic [BIT_W-1:0] idx);
		sig_t m;
		m = '0;
		if ({1'b0, idx} < (BIT_W + 1)'(SIG_BITS)) begin
			m[idx] = 1'b1;
		end
		return m;
	endfunction

endpackage

// ===== src/eia_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module eia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/entity_id_allocator_with_signatures.sv =====
// Top level of the entity ID allocator: free-ID stack, live bits, signature store.
// Depends on eia_pkg, eia_ram and the assertion macro header.
//
//   word       handshake                 payload
//   request    in_valid / in_stall       op, entity_id, bit_index
//   result     out_valid / out_stall     new_id, signature, flag, error
//
// One request is accepted per cycle unless in_stall is raised; each result passes through
// the stage register, which captures the request with the registered RAM reads, then the
// result register. Writes to the stack and signature RAMs are forwarded to the read
// of the following request. Reset clears the live bits and the stack-entry valid bits
// at once, so requests are taken from the first cycle; no clearing pass is run.
// A stalled result holds the stage register, which then stalls the request side.
module entity_id_allocator_with_signatures (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [eia_pkg::OP_W-1:0]   op,
	input  logic [eia_pkg::ID_W-1:0]   entity_id,
	input  logic [eia_pkg::BIT_W-1:0]  bit_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [eia_pkg::ID_W-1:0]   new_id,
	output logic [eia_pkg::SIG_BITS-1:0] signature,
	output logic                       flag,
	output logic [eia_pkg::ERR_W-1:0]  error
);

	import eia_pkg::*;

	`include "entity_id_allocator_with_signatures_macros.svh"

	// Architectural state held in flops.
	top_t                stack_top_q;
	logic [ID_COUNT-1:0] live_q;
	logic [ID_COUNT-1:0] fs_valid_q;

	// Stage one: request plus forwarding information.
	logic                s1_valid;
	logic [OP_W-1:0]     op_s1;
	id_t                 id_s1;
	logic [BIT_W-1:0]    bit_s1;
	id_t                 fs_addr_s1;
	logic                fs_init_s1;
	logic                fs_hit_s1;
	id_t                 fs_byp_s1;
	logic                sig_hit_s1;
	sig_t                sig_byp_s1;

	// Result register.
	logic                out_valid_q;
	id_t                 new_id_q;
	sig_t                signature_q;
	logic                flag_q;
	err_t                error_q;

	// Handshake and flow control.
	logic in_accept;
	logic s1_adv;
	logic s1_fire;

	assign s1_adv    = !out_valid_q || !out_stall;
	assign s1_fire   = s1_valid && s1_adv;
	assign in_stall  = s1_valid && !s1_adv;
	assign in_accept = in_valid && !in_stall;

	// RAM interfaces.
	logic fs_we;
	logic fs_we_g;
	id_t  fs_waddr;
	id_t  fs_wdata;
	id_t  fs_raddr;
	id_t  fs_ram_q;
	logic sig_we;
	logic sig_we_g;
	id_t  sig_waddr;
	sig_t sig_wdata;
	sig_t sig_ram_q;

	assign fs_we_g  = s1_fire && fs_we;
	assign sig_we_g = s1_fire && sig_we;

	eia_ram #(
		.WIDTH (ID_W),
		.DEPTH (ID_COUNT)
	) u_stack_ram (
		.clk   (clk),
		.we    (fs_we_g),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.re    (in_accept),
		.raddr (fs_raddr),
		.rdata (fs_ram_q)
	);

	eia_ram #(
		.WIDTH (SIG_BITS),
		.DEPTH (ID_COUNT)
	) u_sig_ram (
		.clk   (clk),
		.we    (sig_we_g),
		.waddr (sig_waddr),
		.wdata (sig_wdata),
		.re    (in_accept),
		.raddr (entity_id),
		.rdata (sig_ram_q)
	);

	// Resolve the stage-one read data from the forwarded write, the RAM or the reset value.
	id_t  fs_word;
	sig_t sig_word;
	sig_t mask;
	logic id_live;
	top_t top_dec;

	assign fs_word  = fs_hit_s1 ? fs_byp_s1 : (fs_init_s1 ? fs_ram_q : fs_addr_s1);
	assign sig_word = sig_hit_s1 ? sig_byp_s1 : sig_ram_q;
	assign mask     = bit_mask(bit_s1);
	assign id_live  = live_q[id_s1];
	assign top_dec  = stack_top_q - TOP_W'(1);

	// Operation decode: result word, state updates and RAM writes.
	top_t top_d;
	logic live_set;
	logic live_clr;
	logic create_ok;
	id_t  res_new_id;
	sig_t res_sig;
	logic res_flag;
	err_t res_err;

	always_comb begin
		top_d      = stack_top_q;
		live_set   = 1'b0;
		live_clr   = 1'b0;
		create_ok  = 1'b0;
		fs_we      = 1'b0;
		fs_waddr   = top_dec[ID_W-1:0];
		fs_wdata   = id_s1;
		sig_we     = 1'b0;
		sig_waddr  = id_s1;
		sig_wdata  = '0;
		res_new_id = '0;
		res_sig    = '0;
		res_flag   = 1'b0;
		res_err    = ERR_NONE;
		unique case (op_t'(op_s1))
			OP_CREATE: begin
				if (stack_top_q >= TOP_W'(ID_COUNT)) begin
					res_err = ERR_NO_FREE;
				end else begin
					create_ok  = 1'b1;
					res_new_id = fs_word;
					top_d      = stack_top_q + TOP_W'(1);
					sig_we     = 1'b1;
					sig_waddr  = fs_word;
					live_set   = 1'b1;
				end
			end
			OP_DESTROY: begin
				if (id_live && (stack_top_q != '0)) begin
					top_d    = top_dec;
					fs_we    = 1'b1;
					live_clr = 1'b1;
				end
			end
			OP_SET, OP_CLEAR: begin
				if (!id_live) begin
					res_err = ERR_NOT_LIVE;
					res_sig = '1;
				end else begin
					if (op_t'(op_s1) == OP_SET) begin
						sig_wdata = sig_word | mask;
					end else begin
						sig_wdata = sig_word & ~mask;
					end
					sig_we  = 1'b1;
					res_sig = sig_wdata;
				end
			end
			OP_TEST_BIT: begin
				if (!id_live) begin
					res_err = ERR_NOT_LIVE;
					res_sig = '1;
				end else begin
					res_flag = |(sig_word & mask);
				end
			end
			OP_TEST_LIVE: begin
				res_flag = id_live;
			end
			default: begin
			end
		endcase
	end

	// The stack read for the next request follows the top as this request leaves it.
	top_t top_nx;

	assign top_nx   = s1_fire ? top_d : stack_top_q;
	assign fs_raddr = top_nx[ID_W-1:0];

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
			stack_top_q <= TOP_W'(1);
			live_q      <= '0;
			fs_valid_q  <= '0;
		end else begin
			if (in_accept) begin
				s1_valid <= 1'b1;
			end else if (s1_fire) begin
				s1_valid <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			stack_top_q <= top_nx;
			if (s1_fire && live_set) begin
				live_q[fs_word] <= 1'b1;
			end
			if (s1_fire && live_clr) begin
				live_q[id_s1] <= 1'b0;
			end
			if (fs_we_g) begin
				fs_valid_q[fs_waddr] <= 1'b1;
			end
		end
	end

	// Stage-one payload and forwarding capture.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1      <= op;
			id_s1      <= entity_id;
			bit_s1     <= bit_index;
			fs_addr_s1 <= fs_raddr;
			fs_init_s1 <= fs_valid_q[fs_raddr] || (fs_we_g && (fs_waddr == fs_raddr));
			fs_hit_s1  <= fs_we_g && (fs_waddr == fs_raddr);
			fs_byp_s1  <= fs_wdata;
			sig_hit_s1 <= sig_we_g && (sig_waddr == entity_id);
			sig_byp_s1 <= sig_wdata;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			new_id_q    <= res_new_id;
			signature_q <= res_sig;
			flag_q      <= res_flag;
			error_q     <= res_err;
		end
	end

	assign out_valid = out_valid_q;
	assign new_id    = new_id_q;
	assign signature = signature_q;
	assign flag      = flag_q;
	assign error     = error_q;

	// Checks on the stack pointer, the stall path and failed creates.
	`EIA_ASSERT_IMP(a_top_range, 1'b1, (stack_top_q != '0) && (stack_top_q <= TOP_W'(ID_COUNT)))
	`EIA_ASSERT_NXT(a_create_pop, s1_fire && create_ok, stack_top_q == $past(stack_top_q) + TOP_W'(1))
	`EIA_ASSERT_IMP(a_stall_src, in_stall, s1_valid && out_valid_q && out_stall)
	`EIA_ASSERT_IMP(a_no_free_id, out_valid_q && (error_q == ERR_NO_FREE), new_id_q == '0)

endmodule

// ===== tb/sv/entity_id_allocator_with_signatures_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the entity ID allocator: directed and random request words.
// Depends on eia_pkg and the entity_id_allocator_with_signatures RTL.
module entity_id_allocator_with_signatures_tb;
	import eia_pkg::*;

	typedef logic [OP_W-1:0]  code_t;
	typedef logic [BIT_W-1:0] bit_idx_t;

	// Op codes that the allocator does not define; they must have no effect.
	localparam code_t OP_SPARE_A = 3'd6;
	localparam code_t OP_SPARE_B = 3'd7;

	typedef struct packed {
		id_t  new_id;
		sig_t signature;
		logic flag;
		err_t error;
	} reply_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	code_t    op        = '0;
	id_t      entity_id = '0;
	bit_idx_t bit_index = '0;
	logic     out_stall = 1'b0;
	logic     in_stall;
	logic     out_valid;
	id_t      new_id;
	sig_t     signature;
	logic     flag;
	logic [ERR_W-1:0] error;

	// Shadow copy of the allocator state.
	id_t  free_ids [ID_COUNT];
	top_t free_top;
	sig_t sig_store [ID_COUNT];
	bit   is_live [ID_COUNT];

	reply_t replies_due [$];
	bit     idle_on = 1'b1;
	int     words_sent;
	int     results_checked;
	int     refused_creates;
	int     dead_id_errors;
	int     mismatches;

	entity_id_allocator_with_signatures dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.entity_id (entity_id),
		.bit_index (bit_index),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_id    (new_id),
		.signature (signature),
		.flag      (flag),
		.error     (error)
	);

	always #5 clk = ~clk;

	// The result side stalls at random while idling is enabled.
	always @(posedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < 31);
	end

	// Apply one request to the shadow state and return the reply it must produce.
	function automatic reply_t compute_reply(input code_t code, input id_t id,
			input bit_idx_t idx);
		reply_t r;
		sig_t   m;
		r = '0;
		m = (idx < SIG_BITS) ? (sig_t'(1) << idx) : '0;
		case (code)
			OP_CREATE: begin
				if (free_top >= ID_COUNT) begin
					r.error = ERR_NO_FREE;
				end else begin
					r.new_id = free_ids[free_top[ID_W-1:0]];
					free_top = free_top + 1'b1;
					sig_store[r.new_id] = '0;
					is_live[r.new_id] = 1'b1;
				end
			end
			OP_DESTROY: begin
				// A destroy of a dead ID is silently dropped.
				if (is_live[id] && free_top > 0) begin
					free_top = free_top - 1'b1;
					free_ids[free_top[ID_W-1:0]] = id;
					is_live[id] = 1'b0;
				end
			end
			OP_SET, OP_CLEAR: begin
				if (!is_live[id]) begin
					r.error = ERR_NOT_LIVE;
					r.signature = '1;
				end else begin
					if (code == OP_SET) begin
						sig_store[id] = sig_store[id] | m;
					end else begin
						sig_store[id] = sig_store[id] & ~m;
					end
					r.signature = sig_store[id];
				end
			end
			OP_TEST_BIT: begin
				if (!is_live[id]) begin
					r.error = ERR_NOT_LIVE;
					r.signature = '1;
				end else begin
					r.flag = |(sig_store[id] & m);
				end
			end
			OP_TEST_LIVE: begin
				r.flag = is_live[id];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Find a live ID, scanning from a random start; returns 0 when none is live.
	function automatic bit pick_live_id(output id_t id);
		int start;
		start = $urandom_range(ID_COUNT - 1);
		id = '0;
		for (int k = 0; k < ID_COUNT; k++) begin
			id = id_t'((start + k) % ID_COUNT);
			if (is_live[id]) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Mostly a live ID, sometimes any ID at all.
	function automatic id_t choose_target();
		id_t id;
		if ($urandom_range(99) < 85 && pick_live_id(id)) return id;
		return id_t'($urandom_range(ID_COUNT - 1));
	endfunction

	function automatic bit_idx_t any_bit();
		return bit_idx_t'($urandom_range((1 << BIT_W) - 1));
	endfunction

	// Send one request word and record its reply once it is accepted.
	task automatic send_request(input code_t code, input id_t id, input bit_idx_t idx);
		reply_t r;
		logic   stalled;
		while (idle_on && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= code;
		entity_id <= id;
		bit_index <= idx;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		r = compute_reply(code, id, idx);
		replies_due.push_back(r);
		words_sent++;
		if (r.error == ERR_NO_FREE) refused_creates++;
		if (r.error == ERR_NOT_LIVE) dead_id_errors++;
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Compare every accepted result word with the oldest outstanding reply.
	initial begin : result_checker
		logic   took;
		id_t    got_id;
		sig_t   got_sig;
		logic   got_flag;
		logic [ERR_W-1:0] got_err;
		reply_t want;
		forever begin
			@(negedge clk);
			took     = arst_n && out_valid && !out_stall;
			got_id   = new_id;
			got_sig  = signature;
			got_flag = flag;
			got_err  = error;
			@(posedge clk);
			if (took) begin
				if (replies_due.size() == 0) begin
					$display("%0t: result word with nothing outstanding: %s",
						$time, "unexpected word");
					$display("  id 0x%0h sig 0x%0h flag %0b err %0d",
						got_id, got_sig, got_flag, got_err);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					check_field("new_id", 32'(want.new_id), 32'(got_id));
					check_field("signature", 32'(want.signature), 32'(got_sig));
					check_field("flag", 32'(want.flag), 32'(got_flag));
					check_field("error", 32'(want.error), 32'(got_err));
					results_checked++;
				end
			end
		end
	end

	// Dead IDs, ID 0, spare op codes, LIFO reuse and a cleared signature on reuse.
	task automatic test_directed();
		send_request(OP_TEST_LIVE, 8'd1, 5'd0);
		send_request(OP_SET, 8'd0, 5'd0);
		send_request(OP_DESTROY, 8'd1, 5'd31);
		send_request(OP_CREATE, 8'hFF, 5'd31);
		send_request(OP_CREATE, 8'h00, 5'd0);
		send_request(OP_TEST_LIVE, 8'd1, 5'd0);
		send_request(OP_SET, 8'd1, 5'd0);
		send_request(OP_SET, 8'd1, 5'd31);
		send_request(OP_TEST_BIT, 8'd1, 5'd31);
		send_request(OP_TEST_BIT, 8'd1, 5'd30);
		send_request(OP_CLEAR, 8'd1, 5'd0);
		send_request(OP_CLEAR, 8'd2, 5'd31);
		send_request(OP_TEST_BIT, 8'hFF, 5'd5);
		send_request(OP_CLEAR, 8'hFF, 5'd31);
		send_request(OP_TEST_LIVE, 8'hFF, 5'd0);
		send_request(OP_SPARE_A, 8'hFF, 5'd31);
		send_request(OP_SPARE_B, 8'd1, 5'd0);
		send_request(OP_DESTROY, 8'd1, 5'd0);
		send_request(OP_DESTROY, 8'd1, 5'd0);
		send_request(OP_SET, 8'd1, 5'd3);
		send_request(OP_CREATE, 8'h55, 5'd10);
		send_request(OP_TEST_BIT, 8'd1, 5'd31);
		send_request(OP_DESTROY, 8'd2, 5'd0);
		send_request(OP_DESTROY, 8'd1, 5'd0);
	endtask

	// A signature with every bit set must still read as live.
	task automatic test_full_signature();
		id_t  id;
		top_t slot;
		send_request(OP_CREATE, 8'hAA, 5'd21);
		slot = free_top - 1'b1;
		id = free_ids[slot[ID_W-1:0]];
		for (int b = 0; b < SIG_BITS; b++) begin
			send_request(OP_SET, id, bit_idx_t'(b));
		end
		send_request(OP_TEST_LIVE, id, 5'd0);
		send_request(OP_TEST_BIT, id, 5'd17);
		send_request(OP_CLEAR, id, 5'd0);
		send_request(OP_DESTROY, id, 5'd0);
	endtask

	// Drain the free stack, hit the empty-stack refusal, then free every ID again.
	// This phase runs back to back with no idling on either side.
	task automatic test_exhaustion();
		id_t id;
		idle_on = 1'b0;
		while (free_top < ID_COUNT) begin
			send_request(OP_CREATE, id_t'($urandom_range(ID_COUNT - 1)), any_bit());
			if ($urandom_range(99) < 20) send_request(OP_SET, choose_target(), any_bit());
		end
		repeat (3) send_request(OP_CREATE, id_t'($urandom_range(ID_COUNT - 1)), any_bit());
		send_request(OP_TEST_LIVE, 8'hFF, 5'd0);
		send_request(OP_TEST_BIT, choose_target(), any_bit());
		while (pick_live_id(id)) begin
			send_request(OP_DESTROY, id, any_bit());
			if ($urandom_range(99) < 15) send_request(OP_TEST_LIVE, id, any_bit());
		end
		send_request(OP_CREATE, 8'h0F, 5'd15);
		idle_on = 1'b1;
	endtask

	// Weighted mix of well-formed requests on live IDs, with some noise.
	task automatic test_random(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 16) begin
				send_request(OP_CREATE, id_t'($urandom_range(ID_COUNT - 1)), any_bit());
			end else if (pick < 30) begin
				send_request(OP_DESTROY, choose_target(), any_bit());
			end else if (pick < 50) begin
				send_request(OP_SET, choose_target(), any_bit());
			end else if (pick < 64) begin
				send_request(OP_CLEAR, choose_target(), any_bit());
			end else if (pick < 78) begin
				send_request(OP_TEST_BIT, choose_target(), any_bit());
			end else if (pick < 88) begin
				send_request(OP_TEST_LIVE, choose_target(), any_bit());
			end else begin
				send_request(code_t'($urandom_range((1 << OP_W) - 1)),
					id_t'($urandom_range(ID_COUNT - 1)), any_bit());
			end
		end
	endtask

	// Main sequence: reset, tests in turn, drain, verdict.
	initial begin
		for (int i = 0; i < ID_COUNT; i++) begin
			free_ids[i]  = id_t'(i);
			sig_store[i] = '0;
			is_live[i]   = 1'b0;
		end
		free_top = top_t'(1);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_signature();
		test_exhaustion();
		test_random(1300);
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d request words; %0d creates were refused and %0d requests hit dead IDs.",
			words_sent, refused_creates, dead_id_errors);
		$display("Checked %0d result words; %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("PASS entity_id_allocator_with_signatures");
		end else begin
			$display("FAIL entity_id_allocator_with_signatures");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5_000_000;
		$display("Timed out with %0d result words outstanding.", replies_due.size());
		$display("FAIL entity_id_allocator_with_signatures");
		$finish;
	end

endmodule
